// ----- hdl/tnap_pkg.sv -----
// ----------------------------------------------------------------------------
// tnap_pkg
// Shared widths and reset constants for the triangle normal and area unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tnap_pkg;

  // area and threshold word, unsigned Q.32
  localparam int unsigned AREA_W = 49;

  // normal component word, signed Q2.F
  localparam int unsigned UNIT_W = 32;

  // threshold after reset: 0.01 in Q.32
  localparam logic [AREA_W-1:0] AREA_THR_RST = 49'd42949673;

endpackage : tnap_pkg

`default_nettype wire

// ----- hdl/triangle_normal_and_area_unit.sv -----
// ----------------------------------------------------------------------------
// triangle_normal_and_area_unit
// Unit normal (Q2.F) and area (Q.32) of one triangle per clock.
// ----------------------------------------------------------------------------
// Usage: drive the nine vertex coordinates and raise start; a word is taken
// at every clock edge with start high and busy low. busy stays low, so one
// triangle enters every cycle, back to back.
// Each result appears on the result ports for one cycle with done_o high.
// The path runs through the edge, product and cross stages, the square and
// sum stages, LW root stages and F+2 divider stages, then one output
// register, with LW = 2*COORD_BITS+3. Throughput is one triangle per cycle;
// the root and divider pipelines retire one bit per stage.
// The threshold register is written on cfg when cfg_valid_i and cfg_ready_o
// are high; cfg_ready_o is always high. Write it only with the pipe empty.
// Reset clears all valid bits and loads the threshold with 0.01 in Q.32;
// words in flight are dropped. The receiver cannot stall, so nothing
// here waits on it.
// A degenerate triangle (zero length) gives a zero normal and area_ok low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module triangle_normal_and_area_unit
  import tnap_pkg::*;
#(
  parameter int unsigned COORD_BITS       = 24,
  parameter int unsigned NORMAL_FRAC_BITS = 30
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [COORD_BITS-1:0]   v0_x_i,
  input  logic [COORD_BITS-1:0]   v0_y_i,
  input  logic [COORD_BITS-1:0]   v0_z_i,
  input  logic [COORD_BITS-1:0]   v1_x_i,
  input  logic [COORD_BITS-1:0]   v1_y_i,
  input  logic [COORD_BITS-1:0]   v1_z_i,
  input  logic [COORD_BITS-1:0]   v2_x_i,
  input  logic [COORD_BITS-1:0]   v2_y_i,
  input  logic [COORD_BITS-1:0]   v2_z_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [AREA_W-1:0]       cfg_data_i,
  output logic                    done_o,
  output logic [UNIT_W-1:0]       unit_x_o,
  output logic [UNIT_W-1:0]       unit_y_o,
  output logic [UNIT_W-1:0]       unit_z_o,
  output logic [AREA_W-1:0]       tri_area_o,
  output logic                    area_ok_o
);

  localparam int unsigned CB   = COORD_BITS;
  localparam int unsigned F    = NORMAL_FRAC_BITS;
  localparam int unsigned MW   = 2 * CB + 2;
  localparam int unsigned SW   = 2 * MW + 2;
  localparam int unsigned LW   = MW + 1;
  localparam int unsigned AW   = LW - 1;
  localparam int unsigned SB_W = 3 + 3 * MW;
  localparam int unsigned DDEP = F + 2;

  logic                   acc;
  logic [AREA_W-1:0]      thr_q;

  logic                   x_vld;
  logic [2:0][MW-1:0]     x_mag;
  logic [2:0]             x_neg;

  logic                   s_vld;
  logic [SW-1:0]          s_sum;
  logic [2:0][MW-1:0]     s_mag;
  logic [2:0]             s_neg;

  logic                   r_vld;
  logic [LW-1:0]          r_len;
  logic [SB_W-1:0]        r_sb;
  logic [2:0][MW-1:0]     r_mag;
  logic [2:0]             r_neg;

  logic [AW-1:0]          half;
  logic [AREA_W-1:0]      area_d;
  logic [AREA_W-1:0]      area_dl_q [DDEP];
  logic                   zero_dl_q [DDEP];

  logic [2:0]             d_vld;
  logic [2:0][F:0]        d_quo;
  logic [2:0]             d_neg;

  logic [2:0][UNIT_W-1:0] unit_d, unit_q;
  logic                   done_q;
  logic [AREA_W-1:0]      area_q;
  logic                   ok_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign acc         = start && !busy;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= AREA_THR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thr_q <= cfg_data_i;
    end
  end

  tnap_cross #(.CB(CB), .MW(MW)) u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (acc),
    .v0_i    ({v0_z_i, v0_y_i, v0_x_i}),
    .v1_i    ({v1_z_i, v1_y_i, v1_x_i}),
    .v2_i    ({v2_z_i, v2_y_i, v2_x_i}),
    .valid_o (x_vld),
    .mag_o   (x_mag),
    .neg_o   (x_neg)
  );

  tnap_sqsum #(.MW(MW), .SW(SW)) u_sqsum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (x_vld),
    .mag_i   (x_mag),
    .neg_i   (x_neg),
    .valid_o (s_vld),
    .sum_o   (s_sum),
    .mag_o   (s_mag),
    .neg_o   (s_neg)
  );

  tnap_sqrt #(.LW(LW), .SB_W(SB_W)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_vld),
    .rad_i   (s_sum),
    .sb_i    ({s_neg, s_mag}),
    .valid_o (r_vld),
    .root_o  (r_len),
    .sb_o    (r_sb)
  );

  assign r_neg = r_sb[SB_W-1 -: 3];
  assign r_mag = r_sb[3*MW-1:0];

  // area is half the length, saturated to the area word
  assign half = r_len[LW-1:1];
  if (AW > AREA_W) begin : g_sat
    assign area_d = (|half[AW-1:AREA_W]) ? '1 : half[AREA_W-1:0];
  end else begin : g_ext
    assign area_d = AREA_W'(half);
  end

  // area and zero flag wait out the divider
  always_ff @(posedge clk_i) begin
    area_dl_q[0] <= area_d;
    zero_dl_q[0] <= (r_len == '0);
    for (int i = 1; i < DDEP; i++) begin
      area_dl_q[i] <= area_dl_q[i-1];
      zero_dl_q[i] <= zero_dl_q[i-1];
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_div
    tnap_div #(.MW(MW), .LW(LW), .F(F)) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (r_vld),
      .mag_i   (r_mag[k]),
      .len_i   (r_len),
      .neg_i   (r_neg[k]),
      .valid_o (d_vld[k]),
      .quo_o   (d_quo[k]),
      .neg_o   (d_neg[k])
    );
  end

  // apply sign, force zero normal for a degenerate triangle
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (zero_dl_q[DDEP-1]) begin
        unit_d[k] = '0;
      end else if (d_neg[k]) begin
        unit_d[k] = -UNIT_W'(d_quo[k]);
      end else begin
        unit_d[k] = UNIT_W'(d_quo[k]);
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= d_vld[0];
    end
  end

  always_ff @(posedge clk_i) begin
    unit_q <= unit_d;
    area_q <= area_dl_q[DDEP-1];
    ok_q   <= area_dl_q[DDEP-1] > thr_q;
  end

  assign done_o     = done_q;
  assign unit_x_o   = unit_q[0];
  assign unit_y_o   = unit_q[1];
  assign unit_z_o   = unit_q[2];
  assign tri_area_o = area_q;
  assign area_ok_o  = ok_q;

endmodule : triangle_normal_and_area_unit

`default_nettype wire

// ----- hdl/tnap_cross.sv -----
// ----------------------------------------------------------------------------
// tnap_cross
// Three-stage edge, product and cross product pipeline; gives sign and
// magnitude of each cross component.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tnap_cross #(
  parameter int unsigned CB = 24,
  parameter int unsigned MW = 2 * CB + 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [2:0][CB-1:0]     v0_i,
  input  logic [2:0][CB-1:0]     v1_i,
  input  logic [2:0][CB-1:0]     v2_i,
  output logic                   valid_o,
  output logic [2:0][MW-1:0]     mag_o,
  output logic [2:0]             neg_o
);

  localparam int unsigned EW = CB + 1;
  localparam int unsigned PW = 2 * EW;
  localparam int unsigned CW = PW + 1;

  logic [2:0]             vld_q;
  logic [2:0][EW-1:0]     e1_q, e2_q;
  logic signed [PW-1:0]   p_d [6];
  logic signed [PW-1:0]   p_q [6];
  logic signed [CW-1:0]   c_d [3];
  logic [2:0][MW-1:0]     mag_d, mag_q;
  logic [2:0]             neg_d, neg_q;

  // valid bits travel with the words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  // stage 1: edges from the first vertex
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      e1_q[k] <= {v1_i[k][CB-1], v1_i[k]} - {v0_i[k][CB-1], v0_i[k]};
      e2_q[k] <= {v2_i[k][CB-1], v2_i[k]} - {v0_i[k][CB-1], v0_i[k]};
    end
  end

  // stage 2: six signed products
  always_comb begin
    p_d[0] = $signed(e1_q[1]) * $signed(e2_q[2]);
    p_d[1] = $signed(e1_q[2]) * $signed(e2_q[1]);
    p_d[2] = $signed(e1_q[2]) * $signed(e2_q[0]);
    p_d[3] = $signed(e1_q[0]) * $signed(e2_q[2]);
    p_d[4] = $signed(e1_q[0]) * $signed(e2_q[1]);
    p_d[5] = $signed(e1_q[1]) * $signed(e2_q[0]);
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 6; k++) begin
      p_q[k] <= p_d[k];
    end
  end

  // stage 3: cross components split into sign and magnitude
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c_d[k]   = p_q[2*k] - p_q[2*k+1];
      neg_d[k] = c_d[k][CW-1];
      mag_d[k] = neg_d[k] ? MW'(-c_d[k]) : MW'(c_d[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    neg_q <= neg_d;
  end

  assign valid_o = vld_q[2];
  assign mag_o   = mag_q;
  assign neg_o   = neg_q;

endmodule : tnap_cross

`default_nettype wire

// ----- hdl/tnap_sqsum.sv -----
// ----------------------------------------------------------------------------
// tnap_sqsum
// Squares the three magnitudes from half-width partial products and sums
// them, three stages; sign and magnitude ride along.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tnap_sqsum #(
  parameter int unsigned MW = 50,
  parameter int unsigned SW = 2 * MW + 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [2:0][MW-1:0]     mag_i,
  input  logic [2:0]             neg_i,
  output logic                   valid_o,
  output logic [SW-1:0]          sum_o,
  output logic [2:0][MW-1:0]     mag_o,
  output logic [2:0]             neg_o
);

  localparam int unsigned HW  = MW / 2;
  localparam int unsigned SQW = 2 * MW;

  logic [2:0]             vld_q;
  logic [2:0][MW-1:0]     hh_q, hl_q, ll_q;
  logic [2:0][SQW-1:0]    sq_q;
  logic [SW-1:0]          sum_q;
  logic [2:0][MW-1:0]     mag_a_q, mag_b_q, mag_c_q;
  logic [2:0]             neg_a_q, neg_b_q, neg_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  // stage A: high*high, high*low, low*low
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      hh_q[k] <= MW'(mag_i[k][MW-1:HW]) * MW'(mag_i[k][MW-1:HW]);
      hl_q[k] <= MW'(mag_i[k][MW-1:HW]) * MW'(mag_i[k][HW-1:0]);
      ll_q[k] <= MW'(mag_i[k][HW-1:0]) * MW'(mag_i[k][HW-1:0]);
    end
  end

  // stage B: combine partial products into squares
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      sq_q[k] <= {hh_q[k], {MW{1'b0}}} + (SQW'(hl_q[k]) << (HW + 1)) + SQW'(ll_q[k]);
    end
  end

  // stage C: sum of squares
  always_ff @(posedge clk_i) begin
    sum_q <= SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
  end

  // side words delayed to match
  always_ff @(posedge clk_i) begin
    mag_a_q <= mag_i;
    mag_b_q <= mag_a_q;
    mag_c_q <= mag_b_q;
    neg_a_q <= neg_i;
    neg_b_q <= neg_a_q;
    neg_c_q <= neg_b_q;
  end

  assign valid_o = vld_q[2];
  assign sum_o   = sum_q;
  assign mag_o   = mag_c_q;
  assign neg_o   = neg_c_q;

endmodule : tnap_sqsum

`default_nettype wire

// ----- hdl/tnap_sqrt.sv -----
// ----------------------------------------------------------------------------
// tnap_sqrt
// Pipelined integer square root, one root bit per stage (LW stages),
// rounded down; a side word travels with each operand.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tnap_sqrt #(
  parameter int unsigned LW   = 51,
  parameter int unsigned SB_W = 153
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [2*LW-1:0]   rad_i,
  input  logic [SB_W-1:0]   sb_i,
  output logic              valid_o,
  output logic [LW-1:0]     root_o,
  output logic [SB_W-1:0]   sb_o
);

  localparam int unsigned SW = 2 * LW;
  localparam int unsigned RW = LW + 3;

  logic [LW-1:0]     vld_q;
  logic [RW-1:0]     rem_q  [LW];
  logic [LW-1:0]     root_q [LW];
  logic [SW-1:0]     rad_q  [LW];
  logic [SB_W-1:0]   sb_q   [LW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LW-2:0], valid_i};
    end
  end

  for (genvar g = 0; g < LW; g++) begin : g_stg
    logic [RW-1:0]   rem_in, rem_sh, trial;
    logic [LW-1:0]   root_in;
    logic [SW-1:0]   rad_in;
    logic [SB_W-1:0] sb_in;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign sb_in   = sb_i;
    end else begin : g_rest
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign rad_in  = rad_q[g-1];
      assign sb_in   = sb_q[g-1];
    end

    // bring down two radicand bits, try root*4+1
    assign rem_sh = {rem_in[RW-3:0], rad_in[SW-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (rem_sh >= trial) begin
        rem_q[g]  <= rem_sh - trial;
        root_q[g] <= {root_in[LW-2:0], 1'b1};
      end else begin
        rem_q[g]  <= rem_sh;
        root_q[g] <= {root_in[LW-2:0], 1'b0};
      end
      rad_q[g] <= rad_in << 2;
      sb_q[g]  <= sb_in;
    end
  end

  assign valid_o = vld_q[LW-1];
  assign root_o  = root_q[LW-1];
  assign sb_o    = sb_q[LW-1];

endmodule : tnap_sqrt

`default_nettype wire

// ----- hdl/tnap_div.sv -----
// ----------------------------------------------------------------------------
// tnap_div
// Pipelined restoring divider for one normal component: rounds
// mag * 2^F / len to nearest, one quotient bit per stage after a setup stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tnap_div #(
  parameter int unsigned MW = 50,
  parameter int unsigned LW = 51,
  parameter int unsigned F  = 30
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [MW-1:0]   mag_i,
  input  logic [LW-1:0]   len_i,
  input  logic            neg_i,
  output logic            valid_o,
  output logic [F:0]      quo_o,
  output logic            neg_o
);

  localparam int unsigned NW  = MW + F + 1;
  localparam int unsigned DEP = F + 1;

  logic [DEP:0]      vld_q;
  logic [NW-1:0]     num_q;
  logic [LW-1:0]     len_p_q;
  logic              neg_p_q;
  logic [LW-1:0]     rem_q  [DEP];
  logic [F:0]        nlo_q  [DEP];
  logic [F:0]        quo_q  [DEP];
  logic [LW-1:0]     len_q  [DEP];
  logic              neg_q  [DEP];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DEP-1:0], valid_i};
    end
  end

  // setup: numerator with half the divisor added for rounding
  always_ff @(posedge clk_i) begin
    num_q   <= NW'({mag_i, {F{1'b0}}}) + NW'(len_i[LW-1:1]);
    len_p_q <= len_i;
    neg_p_q <= neg_i;
  end

  for (genvar g = 0; g < DEP; g++) begin : g_stg
    logic [LW-1:0] rem_in, len_in;
    logic [F:0]    nlo_in, quo_in;
    logic          neg_in;
    logic [LW:0]   rem_sh;

    if (g == 0) begin : g_first
      // high part of the numerator is already below the divisor
      assign rem_in = LW'(num_q[NW-1:F+1]);
      assign nlo_in = num_q[F:0];
      assign quo_in = '0;
      assign len_in = len_p_q;
      assign neg_in = neg_p_q;
    end else begin : g_rest
      assign rem_in = rem_q[g-1];
      assign nlo_in = nlo_q[g-1];
      assign quo_in = quo_q[g-1];
      assign len_in = len_q[g-1];
      assign neg_in = neg_q[g-1];
    end

    assign rem_sh = {rem_in, nlo_in[F]};

    always_ff @(posedge clk_i) begin
      if (rem_sh >= {1'b0, len_in}) begin
        rem_q[g] <= LW'(rem_sh - {1'b0, len_in});
        quo_q[g] <= {quo_in[F-1:0], 1'b1};
      end else begin
        rem_q[g] <= LW'(rem_sh);
        quo_q[g] <= {quo_in[F-1:0], 1'b0};
      end
      nlo_q[g] <= nlo_in << 1;
      len_q[g] <= len_in;
      neg_q[g] <= neg_in;
    end
  end

  assign valid_o = vld_q[DEP];
  assign quo_o   = quo_q[DEP-1];
  assign neg_o   = neg_q[DEP-1];

endmodule : tnap_div

`default_nettype wire

// ----- hdl/tnap_checker.sv -----
// ----------------------------------------------------------------------------
// tnap_checker
// Port-level checks on result words of the triangle normal and area unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tnap_checker
  import tnap_pkg::*;
#(
  parameter int unsigned NORMAL_FRAC_BITS = 30
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              done_o,
  input logic [UNIT_W-1:0] unit_x_o,
  input logic [UNIT_W-1:0] unit_y_o,
  input logic [UNIT_W-1:0] unit_z_o,
  input logic [AREA_W-1:0] tri_area_o,
  input logic              area_ok_o
);

  localparam logic signed [UNIT_W-1:0] ONE  = UNIT_W'(64'd1 << NORMAL_FRAC_BITS);
  localparam logic signed [UNIT_W-1:0] MONE = -ONE;

  // a passing area is never zero
  a_ok_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && area_ok_o |-> tri_area_o != '0)
    else $error("area_ok with zero area");

  // an all-zero normal marks a degenerate triangle, which never passes
  a_zero_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && unit_x_o == '0 && unit_y_o == '0 && unit_z_o == '0 |-> !area_ok_o)
    else $error("zero normal with area_ok");

  // components stay within one in magnitude
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($signed(unit_x_o) <= ONE && $signed(unit_x_o) >= MONE &&
                $signed(unit_y_o) <= ONE && $signed(unit_y_o) >= MONE &&
                $signed(unit_z_o) <= ONE && $signed(unit_z_o) >= MONE))
    else $error("normal component out of range");

endmodule : tnap_checker

bind triangle_normal_and_area_unit tnap_checker #(
  .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
) u_tnap_checker (.*);

`default_nettype wire

// ----- tb/tb_triangle_normal_and_area_unit.sv -----
// ----------------------------------------------------------------------------
// tb_triangle_normal_and_area_unit
// Self-checking bench for the triangle normal and area unit.
// ----------------------------------------------------------------------------
// Triangles are sent on the start/busy port. A bit-exact predictor computes
// the unit normal, area and threshold flag of each accepted word. A checker
// compares every done_o word against the oldest prediction. The run covers
// directed corner triangles, several threshold settings and random meshes
// with random idle bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_triangle_normal_and_area_unit;
  import tnap_pkg::*;

  localparam int CB = 24;
  localparam int FB = 30;
  localparam int LATENCY = 90;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

  typedef struct packed {
    logic [UNIT_W-1:0] ux;
    logic [UNIT_W-1:0] uy;
    logic [UNIT_W-1:0] uz;
    logic [AREA_W-1:0] area;
    logic              ok;
  } normal_word_t;

  typedef logic signed [CB-1:0] coord_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  coord_t vx [9];
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [AREA_W-1:0] cfg_data_i = '0;
  logic done_o;
  logic [UNIT_W-1:0] unit_x_o, unit_y_o, unit_z_o;
  logic [AREA_W-1:0] tri_area_o;
  logic area_ok_o;

  logic [AREA_W-1:0] thr_model;
  normal_word_t expected_normals[$];
  int mismatches = 0;
  int cycles = 0;
  bit idle_en = 1'b1;

  initial for (int i = 0; i < 9; i++) vx[i] = '0;

  triangle_normal_and_area_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .v0_x_i(vx[0]), .v0_y_i(vx[1]), .v0_z_i(vx[2]),
    .v1_x_i(vx[3]), .v1_y_i(vx[4]), .v1_z_i(vx[5]),
    .v2_x_i(vx[6]), .v2_y_i(vx[7]), .v2_z_i(vx[8]),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .done_o(done_o), .unit_x_o(unit_x_o), .unit_y_o(unit_y_o), .unit_z_o(unit_z_o),
    .tri_area_o(tri_area_o), .area_ok_o(area_ok_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // rounded quotient of one cross component by the length
  function automatic logic [UNIT_W-1:0] unit_of(longint c, logic [127:0] len);
    logic [127:0] m, q;
    m = (c < 0) ? -c : c;
    q = ((m << FB) + (len >> 1)) / len;
    if (c < 0) q = -q;
    return q[UNIT_W-1:0];
  endfunction

  function automatic normal_word_t predict_normal(coord_t v[9]);
    longint e1[3], e2[3], c[3];
    logic [127:0] s, m, r, t;
    normal_word_t w;
    for (int i = 0; i < 3; i++) begin
      e1[i] = longint'(v[3+i]) - longint'(v[i]);
      e2[i] = longint'(v[6+i]) - longint'(v[i]);
    end
    c[0] = e1[1] * e2[2] - e1[2] * e2[1];
    c[1] = e1[2] * e2[0] - e1[0] * e2[2];
    c[2] = e1[0] * e2[1] - e1[1] * e2[0];
    s = '0;
    for (int i = 0; i < 3; i++) begin
      m = (c[i] < 0) ? -c[i] : c[i];
      s = s + m * m;
    end
    // floor square root, one bit per pass
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (128'd1 << i);
      if (t * t <= s) r = t;
    end
    w = '0;
    if (r != 0) begin
      w.ux = unit_of(c[0], r);
      w.uy = unit_of(c[1], r);
      w.uz = unit_of(c[2], r);
      w.area = ((r >> 1) > AREA_MAX) ? AREA_MAX : r[AREA_W:1];
      w.ok = w.area > thr_model;
    end
    return w;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    normal_word_t got, exp_w;
    if (done_o) begin
      got = '{unit_x_o, unit_y_o, unit_z_o, tri_area_o, area_ok_o};
      if (expected_normals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
      end else begin
        exp_w = expected_normals.pop_front();
        if (got !== exp_w) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp x=%h y=%h z=%h a=%h ok=%b got x=%h y=%h z=%h a=%h ok=%b",
                     exp_w.ux, exp_w.uy, exp_w.uz, exp_w.area, exp_w.ok,
                     got.ux, got.uy, got.uz, got.area, got.ok);
        end
      end
    end
  end

  // timeout
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL triangle_normal_and_area_unit");
      $finish;
    end
  end

  task automatic idle_burst();
    int n;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 13);
      @(negedge clk_i);
      start = 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_triangle(coord_t v[9]);
    @(negedge clk_i);
    for (int i = 0; i < 9; i++) vx[i] = v[i];
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    expected_normals.push_back(predict_normal(v));
    idle_burst();
  endtask

  // stop sending and let the pipe run dry
  task automatic drain_pipe();
    @(negedge clk_i);
    start = 1'b0;
    while (expected_normals.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
  endtask

  task automatic write_threshold(logic [AREA_W-1:0] thr);
    drain_pipe();
    cfg_valid_i = 1'b1;
    cfg_data_i = thr;
    do @(posedge clk_i); while (!cfg_ready_o);
    thr_model = thr;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic coord_t rand_coord();
    return coord_t'($urandom());
  endfunction

  task automatic send_random_triangle();
    coord_t v[9];
    int kind, k;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) v[i] = rand_coord();
    if (kind < 3) begin
      // small triangle around a random origin, area near the threshold
      for (int i = 3; i < 9; i++)
        v[i] = v[i % 3] + coord_t'($signed($urandom_range(0, 8191)) - 4096);
    end else if (kind == 3) begin
      // collinear: third vertex on the line of the first edge
      k = $urandom_range(0, 3);
      for (int i = 0; i < 3; i++) begin
        v[3+i] = v[i] + coord_t'($signed($urandom_range(0, 4095)) - 2048);
        v[6+i] = v[i] + coord_t'(k * (v[3+i] - v[i]));
      end
    end else if (kind == 4) begin
      for (int i = 0; i < 9; i++)
        v[i] = $urandom_range(0, 1) ? coord_t'({1'b0, {CB-1{1'b1}}}) : coord_t'({1'b1, {CB-1{1'b0}}});
    end
    send_triangle(v);
  endtask

  task automatic test_directed();
    coord_t v[9];
    coord_t cmax, cmin;
    cmax = {1'b0, {CB-1{1'b1}}};
    cmin = {1'b1, {CB-1{1'b0}}};
    v = '{default: '0};
    send_triangle(v);                       // all zero, degenerate
    v = '{0, 0, 0, 65536, 0, 0, 0, 65536, 0}; // unit right triangle in xy
    send_triangle(v);
    v = '{0, 0, 0, 0, 0, 65536, 65536, 0, 0};
    send_triangle(v);
    v = '{0, 0, 0, 0, 65536, 0, 0, 0, 65536};
    send_triangle(v);
    v = '{cmin, cmin, cmin, cmax, cmin, cmin, cmin, cmax, cmin}; // widest edges
    send_triangle(v);
    v = '{cmin, cmin, cmin, cmax, cmax, cmin, cmin, cmax, cmax};
    send_triangle(v);
    v = '{cmax, cmin, cmax, cmin, cmax, cmin, cmax, cmax, cmin};
    send_triangle(v);
    v = '{cmax, cmax, cmax, cmin, cmin, cmin, cmax, cmax, cmax}; // repeated vertex
    send_triangle(v);
    v = '{1, 2, 3, 2, 4, 6, 3, 6, 9};       // collinear
    send_triangle(v);
    v = '{0, 0, 0, 1, 0, 0, 0, 1, 0};       // tiniest area
    send_triangle(v);
    v = '{0, 0, 0, 6554, 0, 0, 0, 6554, 0}; // twice the area close to 0.01
    send_triangle(v);
    v = '{0, 0, 0, 6553, 0, 0, 0, 6553, 0};
    send_triangle(v);
    v = '{-5, 7, -3, 11, -2, 9, 4, 13, -8};
    send_triangle(v);
    v = '{cmin, 0, 0, cmax, 0, 0, 0, cmax, cmin};
    send_triangle(v);
  endtask

  task automatic test_thresholds();
    logic [AREA_W-1:0] thr_list[5];
    thr_list = '{'0, AREA_MAX, 49'd1, AREA_THR_RST, AREA_W'({$urandom(), $urandom()})};
    foreach (thr_list[j]) begin
      write_threshold(thr_list[j]);
      repeat (40) send_random_triangle();
    end
  endtask

  task automatic test_random_mesh();
    repeat (700) send_random_triangle();
    // sender holds off until the pipe is empty, then resumes
    drain_pipe();
    repeat (150) send_random_triangle();
    idle_en = 1'b0;
    repeat (50) send_random_triangle();
  endtask

  initial begin
    thr_model = AREA_THR_RST;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_thresholds();
    test_random_mesh();
    drain_pipe();
    if (mismatches == 0 && expected_normals.size() == 0) begin
      $display("PASS triangle_normal_and_area_unit");
    end else begin
      $display("FAIL triangle_normal_and_area_unit");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/tnap_pkg.sv
hdl/tnap_cross.sv
hdl/tnap_sqsum.sv
hdl/tnap_sqrt.sv
hdl/tnap_div.sv
hdl/triangle_normal_and_area_unit.sv
hdl/tnap_checker.sv
tb/tb_triangle_normal_and_area_unit.sv
